>>> hw/rtl/lcg_pkg.sv
// Shared constants for the line colour gradient block.
// No dependencies; imported by every lcg module and the top level.
`default_nettype none

package lcg_pkg;

  localparam int COORD_BITS_DEF = 16;   // default coordinate width
  localparam int CHAN_W         = 8;    // bits per colour channel
  localparam int NUM_LANES      = 3;    // red, green, blue
  localparam int COLOR_W        = CHAN_W * NUM_LANES;
  localparam int CHAN_MAX       = 255;

  // Quotient bits resolved by the divider; anything at or above 2**QUO_BITS clamps anyway
  localparam int QUO_BITS       = 9;

  // Pipeline layout: front end, lane (product, magnitude, range check,
  // one stage per quotient bit, clamp), then the output register
  localparam int FRONT_STAGES   = 2;
  localparam int LANE_STAGES    = QUO_BITS + 4;
  localparam int PIPE_STAGES    = FRONT_STAGES + LANE_STAGES + 1;

endpackage

`default_nettype wire

>>> hw/rtl/lcg_front.sv
// Front end of the colour gradient pipeline: coordinate differences, axis choice,
// fraction numerator and denominator. Depends on lcg_pkg.
`default_nettype none

module lcg_front
  import lcg_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic [FRONT_STAGES-1:0]       adv,
  input  logic signed [COORD_BITS-1:0]  start_x,
  input  logic signed [COORD_BITS-1:0]  start_y,
  input  logic [COLOR_W-1:0]            start_color,
  input  logic signed [COORD_BITS-1:0]  cur_x,
  input  logic signed [COORD_BITS-1:0]  cur_y,
  input  logic [COLOR_W-1:0]            cur_color,
  input  logic signed [COORD_BITS-1:0]  end_x,
  input  logic signed [COORD_BITS-1:0]  end_y,
  input  logic [COLOR_W-1:0]            end_color,
  output logic signed [COORD_BITS:0]    num,
  output logic signed [COORD_BITS:0]    den,
  output logic [COLOR_W-1:0]            s_color,
  output logic [COLOR_W-1:0]            e_color,
  output logic                          byp
);

  localparam int DW = COORD_BITS + 1;

  // stage 0: differences
  logic signed [DW-1:0] rem_x, rem_y, num_x, num_y, den_x, den_y;
  logic [COLOR_W-1:0]   sc0, ec0;
  logic                 same0;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      rem_x <= DW'(end_x) - DW'(cur_x);
      rem_y <= DW'(end_y) - DW'(cur_y);
      num_x <= DW'(cur_x) - DW'(start_x);
      num_y <= DW'(cur_y) - DW'(start_y);
      den_x <= DW'(end_x) - DW'(start_x);
      den_y <= DW'(end_y) - DW'(start_y);
      sc0   <= start_color;
      ec0   <= end_color;
      same0 <= (cur_color == end_color);
    end
  end

  // stage 1: pick the dominant remaining axis, ties to y
  logic [DW-1:0]        abs_x, abs_y;
  logic                 use_x;
  logic signed [DW-1:0] num_sel, den_sel;

  always_comb begin
    abs_x   = rem_x[DW-1] ? DW'(-rem_x) : DW'(rem_x);
    abs_y   = rem_y[DW-1] ? DW'(-rem_y) : DW'(rem_y);
    use_x   = abs_x > abs_y;
    num_sel = use_x ? num_x : num_y;
    den_sel = use_x ? den_x : den_y;
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      num     <= num_sel;
      den     <= den_sel;
      s_color <= sc0;
      e_color <= ec0;
      // equal colours and a zero-length axis both give the end colour
      byp     <= same0 | (den_sel == '0);
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/lcg_lane.sv
// One colour channel lane: s + floor((e-s)*N/D), saturated to the channel range,
// through a pipelined restoring divider with one quotient bit per stage. Depends on lcg_pkg.
`default_nettype none

module lcg_lane
  import lcg_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                        clk,
  input  logic [LANE_STAGES-1:0]      adv,
  input  logic signed [COORD_BITS:0]  num,
  input  logic signed [COORD_BITS:0]  den,
  input  logic [CHAN_W-1:0]           s_chan,
  input  logic [CHAN_W-1:0]           e_chan,
  input  logic                        byp,
  output logic [CHAN_W-1:0]           chan
);

  localparam int DW = COORD_BITS + 1;
  localparam int PW = DW + QUO_BITS;       // product and remainder width
  localparam int SW = QUO_BITS + 3;        // signed width of s +/- quotient

  // product stage
  logic signed [CHAN_W:0] delta;
  logic signed [PW-1:0]   prod_full;
  logic signed [PW-1:0]   prod;
  logic [DW-1:0]          dmag_a;
  logic                   dneg_a;
  logic [CHAN_W-1:0]      s_a, e_a;
  logic                   byp_a;

  always_comb begin
    delta     = $signed({1'b0, e_chan}) - $signed({1'b0, s_chan});
    prod_full = PW'(delta) * PW'(num);
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      prod   <= prod_full;
      dneg_a <= den[DW-1];
      dmag_a <= den[DW-1] ? DW'(-den) : DW'(den);
      s_a    <= s_chan;
      e_a    <= e_chan;
      byp_a  <= byp;
    end
  end

  // magnitude stage
  logic [PW-1:0]     amag_b;
  logic [DW-1:0]     dmag_b;
  logic              neg_b;
  logic [CHAN_W-1:0] s_b, e_b;
  logic              byp_b;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      amag_b <= prod[PW-1] ? PW'(-prod) : PW'(prod);
      neg_b  <= prod[PW-1] ^ dneg_a;
      dmag_b <= dmag_a;
      s_b    <= s_a;
      e_b    <= e_a;
      byp_b  <= byp_a;
    end
  end

  // range check, then one stage per quotient bit, MSB first
  logic [PW-1:0]       rem_p  [QUO_BITS+1];
  logic [QUO_BITS-1:0] quo_p  [QUO_BITS+1];
  logic [DW-1:0]       dmag_p [QUO_BITS];
  logic                sat_p  [QUO_BITS+1];
  logic                neg_p  [QUO_BITS+1];
  logic [CHAN_W-1:0]   s_p    [QUO_BITS+1];
  logic [CHAN_W-1:0]   e_p    [QUO_BITS+1];
  logic                byp_p  [QUO_BITS+1];

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      sat_p[0]  <= amag_b >= {dmag_b, QUO_BITS'(0)};
      rem_p[0]  <= amag_b;
      quo_p[0]  <= '0;
      dmag_p[0] <= dmag_b;
      neg_p[0]  <= neg_b;
      s_p[0]    <= s_b;
      e_p[0]    <= e_b;
      byp_p[0]  <= byp_b;
    end
  end

  for (genvar k = 1; k <= QUO_BITS; k++) begin : g_div
    localparam int BIT = QUO_BITS - k;
    logic [PW-1:0]       trial;
    logic                take;
    logic [QUO_BITS-1:0] quo_set;

    assign trial   = PW'(dmag_p[k-1]) << BIT;
    assign take    = rem_p[k-1] >= trial;
    assign quo_set = quo_p[k-1] | (QUO_BITS'(take) << BIT);

    always_ff @(posedge clk) begin
      if (adv[2+k]) begin
        rem_p[k]      <= take ? rem_p[k-1] - trial : rem_p[k-1];
        quo_p[k]      <= quo_set;
        sat_p[k]      <= sat_p[k-1];
        neg_p[k]      <= neg_p[k-1];
        s_p[k]        <= s_p[k-1];
        e_p[k]        <= e_p[k-1];
        byp_p[k]      <= byp_p[k-1];
      end
    end

    if (k < QUO_BITS) begin : g_carry
      always_ff @(posedge clk) begin
        if (adv[2+k]) begin
          dmag_p[k] <= dmag_p[k-1];
        end
      end
    end
  end

  // floor for negative fractions: round the magnitude up on a nonzero remainder
  logic [QUO_BITS:0]   mag;
  logic signed [SW-1:0] val;
  logic [CHAN_W-1:0]   clamped;

  always_comb begin
    if (sat_p[QUO_BITS]) begin
      mag = {1'b1, QUO_BITS'(0)};
    end else begin
      mag = {1'b0, quo_p[QUO_BITS]}
            + (QUO_BITS+1)'(neg_p[QUO_BITS] && (rem_p[QUO_BITS] != '0));
    end
    if (neg_p[QUO_BITS]) begin
      val = $signed(SW'(s_p[QUO_BITS])) - $signed(SW'(mag));
    end else begin
      val = $signed(SW'(s_p[QUO_BITS])) + $signed(SW'(mag));
    end
    if (val[SW-1]) begin
      clamped = '0;
    end else if (val > $signed(SW'(CHAN_MAX))) begin
      clamped = CHAN_W'(CHAN_MAX);
    end else begin
      clamped = val[CHAN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[LANE_STAGES-1]) begin
      chan <= byp_p[QUO_BITS] ? e_p[QUO_BITS] : clamped;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/line_color_gradient.sv
// Line colour gradient: interpolates an RGB888 colour for each pixel of a line.
// Slave channel s_* takes one pixel word per handshake; master channel m_* returns
// the interpolated colour. Every word gives exactly one result, in order.
// The fraction along the dominant remaining axis is applied to each channel
// exactly (floor of the rational value), saturated to 0..255; equal current and
// end colours or a zero-length axis return the end colour.
// Throughput: one word per cycle whenever s_tready is high. Pipeline:
// 16 register stages: 2 front-end stages, 13 per-channel lane
// stages of which 9 form the restoring divider resolving one quotient bit each,
// then the output register.
// Three lanes, one per channel, run side by side on the same word.
// Reset (rst, synchronous) empties the pipeline; s_tready rises with the first
// empty stage. When m_tready is low, a valid m_tdata holds and the pipeline keeps
// accepting words until every stage is full, then s_tready drops.
// Depends on lcg_pkg, lcg_front and lcg_lane.
`default_nettype none

module line_color_gradient
  import lcg_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int IN_BITS   = 6 * COORD_BITS + 3 * COLOR_W,
  localparam int IN_W      = ((IN_BITS + 7) / 8) * 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  // start_x, start_y, start_color, cur_x, cur_y, cur_color, end_x, end_y, end_color
  input  logic [IN_W-1:0]    s_tdata,
  output logic               m_tvalid,
  input  logic               m_tready,
  // pixel_color
  output logic [COLOR_W-1:0] m_tdata
);

  localparam int CB = COORD_BITS;

  logic signed [CB-1:0] start_x, start_y, cur_x, cur_y, end_x, end_y;
  logic [COLOR_W-1:0]   start_color, cur_color, end_color;

  assign start_x     = $signed(s_tdata[CB-1:0]);
  assign start_y     = $signed(s_tdata[2*CB-1:CB]);
  assign start_color = s_tdata[2*CB+COLOR_W-1:2*CB];
  assign cur_x       = $signed(s_tdata[3*CB+COLOR_W-1:2*CB+COLOR_W]);
  assign cur_y       = $signed(s_tdata[4*CB+COLOR_W-1:3*CB+COLOR_W]);
  assign cur_color   = s_tdata[4*CB+2*COLOR_W-1:4*CB+COLOR_W];
  assign end_x       = $signed(s_tdata[5*CB+2*COLOR_W-1:4*CB+2*COLOR_W]);
  assign end_y       = $signed(s_tdata[6*CB+2*COLOR_W-1:5*CB+2*COLOR_W]);
  assign end_color   = s_tdata[6*CB+3*COLOR_W-1:6*CB+2*COLOR_W];

  // stage occupancy; a stage loads when m_tready is high or it or any stage after it is empty
  logic [PIPE_STAGES-1:0] valid;
  logic [PIPE_STAGES-1:0] adv;

  for (genvar k = 0; k < PIPE_STAGES; k++) begin : g_adv
    assign adv[k] = m_tready | ~(&valid[PIPE_STAGES-1:k]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (adv[0]) begin
        valid[0] <= s_tvalid;
      end
      for (int k = 1; k < PIPE_STAGES; k++) begin
        if (adv[k]) begin
          valid[k] <= valid[k-1];
        end
      end
    end
  end

  assign s_tready = adv[0];
  assign m_tvalid = valid[PIPE_STAGES-1];

  logic signed [CB:0]   num, den;
  logic [COLOR_W-1:0]   s_color, e_color;
  logic                 byp;

  lcg_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk         (clk),
    .adv         (adv[FRONT_STAGES-1:0]),
    .start_x     (start_x),
    .start_y     (start_y),
    .start_color (start_color),
    .cur_x       (cur_x),
    .cur_y       (cur_y),
    .cur_color   (cur_color),
    .end_x       (end_x),
    .end_y       (end_y),
    .end_color   (end_color),
    .num         (num),
    .den         (den),
    .s_color     (s_color),
    .e_color     (e_color),
    .byp         (byp)
  );

  logic [COLOR_W-1:0] lane_color;

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    lcg_lane #(
      .COORD_BITS(COORD_BITS)
    ) u_lane (
      .clk    (clk),
      .adv    (adv[FRONT_STAGES+LANE_STAGES-1:FRONT_STAGES]),
      .num    (num),
      .den    (den),
      .s_chan (s_color[l*CHAN_W +: CHAN_W]),
      .e_chan (e_color[l*CHAN_W +: CHAN_W]),
      .byp    (byp),
      .chan   (lane_color[l*CHAN_W +: CHAN_W])
    );
  end

  // merge the lanes into the output word; hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (adv[PIPE_STAGES-1]) begin
      m_tdata <= lane_color;
    end
  end

endmodule

`default_nettype wire

>>> test/tb_line_color_gradient.sv
// Self-checking bench for line_color_gradient: drives pixel words on s_*, checks
// the interpolated colours on m_* against a cycle-free predictor.
// Depends on lcg_pkg and the line_color_gradient RTL.
`default_nettype none

module tb_line_color_gradient;
  import lcg_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB = COORD_BITS_DEF;

  // Field order matches s_tdata, first field in the lowest bits
  typedef struct packed {
    logic [COLOR_W-1:0] end_color;
    logic signed [CB-1:0] end_y;
    logic signed [CB-1:0] end_x;
    logic [COLOR_W-1:0] cur_color;
    logic signed [CB-1:0] cur_y;
    logic signed [CB-1:0] cur_x;
    logic [COLOR_W-1:0] start_color;
    logic signed [CB-1:0] start_y;
    logic signed [CB-1:0] start_x;
  } pixel_word_t;

  localparam int WORD_W = $bits(pixel_word_t);

  class color_scoreboard;
    logic [COLOR_W-1:0] expected_colors[$];
    int mismatches;

    function automatic logic [COLOR_W-1:0] blend_pixel(pixel_word_t p);
      longint n, d, dd, s, e, num, q, adx, ady;
      logic [COLOR_W-1:0] c;
      if (p.cur_color == p.end_color) return p.cur_color;
      adx = longint'(p.end_x) - longint'(p.cur_x);
      ady = longint'(p.end_y) - longint'(p.cur_y);
      if (adx < 0) adx = -adx;
      if (ady < 0) ady = -ady;
      // ties go to y
      if (adx > ady) begin
        n = longint'(p.cur_x) - longint'(p.start_x);
        d = longint'(p.end_x) - longint'(p.start_x);
      end else begin
        n = longint'(p.cur_y) - longint'(p.start_y);
        d = longint'(p.end_y) - longint'(p.start_y);
      end
      if (d == 0) return p.end_color;
      for (int ch = 0; ch < NUM_LANES; ch++) begin
        s = longint'(p.start_color[CHAN_W*ch +: CHAN_W]);
        e = longint'(p.end_color[CHAN_W*ch +: CHAN_W]);
        dd = d;
        num = s * (dd - n) + e * n;
        if (dd < 0) begin
          num = -num;
          dd = -dd;
        end
        q = num / dd;
        // floor, not truncation
        if ((num % dd) != 0 && num < 0) q -= 1;
        if (q < 0) q = 0;
        if (q > CHAN_MAX) q = CHAN_MAX;
        c[CHAN_W*ch +: CHAN_W] = q[CHAN_W-1:0];
      end
      return c;
    endfunction

    function void note_pixel(pixel_word_t p);
      expected_colors.push_back(blend_pixel(p));
    endfunction

    function void check_color(logic [COLOR_W-1:0] got);
      logic [COLOR_W-1:0] want;
      if (expected_colors.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected colour word %06h", got);
        return;
      end
      want = expected_colors.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("pixel_color mismatch: expected %06h got %06h", want, got);
      end
    endfunction

    function int pending();
      return expected_colors.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [WORD_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [COLOR_W-1:0] m_tdata;

  color_scoreboard sb = new();
  int src_idle_pct = 15;
  int sink_stall_pct = 76;
  bit hold_req = 1'b0;

  line_color_gradient dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Result side: check accepted words, then pick next cycle's tready
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) sb.check_color(m_tdata);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 80;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  task automatic send_pixel(input pixel_word_t p);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= p;
    do @(posedge clk); while (!s_tready);
    sb.note_pixel(p);
  endtask

  function automatic pixel_word_t mk(int sx, int sy, int sc, int cx, int cy, int cc,
                                     int ex, int ey, int ec);
    pixel_word_t p;
    p.start_x = CB'(sx);
    p.start_y = CB'(sy);
    p.start_color = COLOR_W'(sc);
    p.cur_x = CB'(cx);
    p.cur_y = CB'(cy);
    p.cur_color = COLOR_W'(cc);
    p.end_x = CB'(ex);
    p.end_y = CB'(ey);
    p.end_color = COLOR_W'(ec);
    return p;
  endfunction

  function automatic pixel_word_t random_pixel();
    pixel_word_t p;
    int sx, sy, ex, ey, cx, cy, span, t, jx, jy, pick;
    pick = $urandom_range(99);
    p = WORD_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    if (pick < 20) return p;  // raw noise
    span = ($urandom_range(9) == 0) ? 32767 : $urandom_range(1, 64);
    sx = $urandom_range(65535);
    sx -= 32768;
    sy = $urandom_range(65535);
    sy -= 32768;
    ex = $urandom_range(2 * span);
    ex = sx + ex - span;
    ey = $urandom_range(2 * span);
    ey = sy + ey - span;
    // zero-length axis now and then
    if (pick < 30) begin
      if ($urandom_range(1)) ex = sx;
      else ey = sy;
    end
    t = $urandom_range(256);
    if ($urandom_range(99) < 15) begin
      t = $urandom_range(768);
      t -= 256;
    end
    jx = $urandom_range(4);
    jy = $urandom_range(4);
    cx = sx + ((ex - sx) * t) / 256 + jx - 2;
    cy = sy + ((ey - sy) * t) / 256 + jy - 2;
    p.start_x = CB'(sx);
    p.start_y = CB'(sy);
    p.cur_x = CB'(cx);
    p.cur_y = CB'(cy);
    p.end_x = CB'(ex);
    p.end_y = CB'(ey);
    if ($urandom_range(99) < 15) p.cur_color = p.end_color;
    return p;
  endfunction

  initial begin
    int n_phase;
    int phase_len[3];
    phase_len = '{180, 180, 190};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // same colour, all zero and all ones
    send_pixel(mk(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_pixel(mk(-32768, 32767, 'h123456, 32767, -32768, 'hFFFFFF, 0, 0, 'hFFFFFF));
    // zero-length axis
    send_pixel(mk(5, 5, 'hFF0000, 5, 5, 'h000000, 5, 5, 'h00FF00));
    send_pixel(mk(-7, 3, 'hFFFFFF, 0, 3, 'h808080, 20, 3, 'h000000));
    // x axis, y axis and a tie
    send_pixel(mk(0, 0, 'hFF0000, 50, 5, 'h000000, 100, 10, 'h0000FF));
    send_pixel(mk(0, 0, 'h00FF00, 3, 40, 'h000000, 10, 100, 'hFF00FF));
    send_pixel(mk(0, 0, 'h102030, 20, 20, 'h000000, 30, 30, 'hF0E0D0));
    // descending axis
    send_pixel(mk(100, 0, 'hFFFFFF, 25, 0, 'h010101, 0, 0, 'h000000));
    send_pixel(mk(0, 100, 'h00FF7F, 0, 33, 'h010101, 0, -100, 'hFF0080));
    // off the segment, both ends
    send_pixel(mk(10, 0, 'hFFFFFF, -50, 0, 'h000001, 100, 0, 'h000000));
    send_pixel(mk(10, 0, 'h000000, 300, 0, 'h000001, 100, 0, 'hFFFFFF));
    send_pixel(mk(0, 10, 'h80FF00, 0, 200, 'h000001, 0, 20, 'h00FF80));
    // coordinate extremes
    send_pixel(mk(-32768, 0, 'hFF00FF, 0, 0, 'h123456, 32767, 0, 'h00FF00));
    send_pixel(mk(32767, 0, 'hFFFFFF, -32768, 0, 'h123456, -32768, 1, 'h000000));
    send_pixel(mk(0, -32768, 'h0000FF, 0, 32767, 'h123456, 0, 32767, 'hFF0000));
    send_pixel(mk(32767, -32768, 'h00FFFF, -32768, 32767, 'h123456, 0, 0, 'hFF0000));
    // current point at start and at end
    send_pixel(mk(3, 4, 'hABCDEF, 3, 4, 'h000000, 60, 90, 'h123456));
    send_pixel(mk(3, 4, 'hABCDEF, 60, 90, 'h000000, 60, 90, 'h123456));
    send_pixel(mk(-1, -1, 'h7F7F7F, -1, 0, 'hFFFFFE, 1, 1, 'h808080));

    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin
        src_idle_pct = 76;
        sink_stall_pct = 15;
      end else if (ph == 2) begin
        src_idle_pct = 0;
        sink_stall_pct = 0;
        // hold the output long enough to fill the pipe and stall the input
        hold_req = 1'b1;
      end
      n_phase = 0;
      while (n_phase < phase_len[ph]) begin
        send_pixel(random_pixel());
        n_phase++;
        if (ph == 2 && n_phase == 60) begin
          s_tvalid <= 1'b0;
          while (sb.pending() != 0) @(posedge clk);
        end
      end
    end
    s_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> line_color_gradient.f
hw/rtl/lcg_pkg.sv
hw/rtl/lcg_front.sv
hw/rtl/lcg_lane.sv
hw/rtl/line_color_gradient.sv
test/tb_line_color_gradient.sv
